// File: sv/adsr_eg_pkg.sv
// Shared types, constants and register codes for the AR/ADSR envelope generator.
// No dependencies; every other file of the block imports this package.
package adsr_eg_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int LEVEL_BITS  = 16;

    // Shared multiplier: signed A (sample or zero-extended level) by signed B
    localparam int MUL_A_W = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS + 1;
    localparam int MUL_B_W = LEVEL_BITS + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Ramp-down factor 0.999 in Q0.16
    localparam logic [LEVEL_BITS-1:0] RAMP_FACTOR = 16'd65470;

    // Action codes
    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_NOTE_ON  = 2'd1;
    localparam logic [1:0] ACT_NOTE_OFF = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LEVEL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_FACTOR = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_LEVEL    = 3'd6;

    // Register reset values
    localparam logic                  RST_MODE           = 1'b0;
    localparam logic [LEVEL_BITS-1:0] RST_ATTACK_STEP    = 16'd1;
    localparam logic [LEVEL_BITS-1:0] RST_PEAK_LEVEL     = 16'd58982;
    localparam logic [LEVEL_BITS-1:0] RST_DECAY_FACTOR   = 16'd65500;
    localparam logic [LEVEL_BITS-1:0] RST_SUSTAIN_LEVEL  = 16'd52429;
    localparam logic [LEVEL_BITS-1:0] RST_RELEASE_FACTOR = 16'd65500;
    localparam logic [LEVEL_BITS-1:0] RST_FLOOR_LEVEL    = 16'd66;

    typedef struct packed {
        logic [1:0]                    action;
        logic signed [SAMPLE_BITS-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0]         level;
        logic signed [SAMPLE_BITS-1:0] scaled_sample;
        logic                          start_playback;
        logic                          stop_playback;
    } out_item_t;

    typedef struct packed {
        logic                  mode;
        logic [LEVEL_BITS-1:0] attack_step;
        logic [LEVEL_BITS-1:0] peak_level;
        logic [LEVEL_BITS-1:0] decay_factor;
        logic [LEVEL_BITS-1:0] sustain_level;
        logic [LEVEL_BITS-1:0] release_factor;
        logic [LEVEL_BITS-1:0] floor_level;
    } cfg_regs_t;

endpackage

// File: sv/ar_adsr_envelope_generator.sv
// Top level of the AR/ADSR envelope generator: sequencer, envelope state,
// output register. Depends on adsr_eg_pkg, adsr_eg_cfg and adsr_eg_mul.
//
//  port group   direction  handshake          beat content
//  s_*          in         s_valid/s_ready    action, sample (in_item_t)
//  m_*          out        m_valid/m_ready    level, scaled_sample, flags (out_item_t)
//  cfg_*        in         cfg_wr_en only     register index, write data
//
// A tick beat passes through S_ENV, S_SCALE and S_DONE when the level is
// set directly (attack, sustain, silence), and through S_POST as well,
// after S_ENV, when the level itself is scaled by a factor first.
// Note-on, note-off and unused codes are taken in S_IDLE and give no result.
// s_ready is high only while the sequencer is idle; a finished result sits
// in the output register, and a stalled output holds the sequencer in its
// last step. Reset is synchronous, active low, and clears all envelope state.
module ar_adsr_envelope_generator
    import adsr_eg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [LEVEL_BITS-1:0] cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENV,
        S_POST,
        S_SCALE,
        S_DONE
    } state_t;

    // What to do with the level product once it is back from the multiplier
    typedef enum logic [1:0] {
        P_RAMP,
        P_DECAY,
        P_REL_AR,
        P_REL_ADSR
    } post_t;

    cfg_regs_t cfg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;

    state_t state_reg, state_next;
    post_t  post_reg, post_next;

    logic [LEVEL_BITS-1:0] env_reg, env_next;
    logic trig_reg, trig_next;
    logic held_reg, held_next;
    logic atk_reg, atk_next;
    logic dec_reg, dec_next;
    logic rel_reg, rel_next;
    logic ramp_reg, ramp_next;

    logic [LEVEL_BITS-1:0]         lvl_reg, lvl_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic start_reg, start_next;
    logic stop_reg, stop_next;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    // Attack step, saturated sum and peak test
    logic [LEVEL_BITS:0]   atk_sum;
    logic [LEVEL_BITS-1:0] atk_sat;
    logic                  atk_hit;
    logic [LEVEL_BITS-1:0] atk_lvl;

    // Level product and truncated scaled sample
    logic [LEVEL_BITS-1:0]             prod_lvl;
    logic signed [MUL_P_W-LEVEL_BITS-1:0] prod_hi;
    logic                              prod_round;
    logic signed [MUL_P_W-LEVEL_BITS-1:0] scaled;

    adsr_eg_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    adsr_eg_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign atk_sum = {1'b0, env_reg} + {1'b0, cfg.attack_step};
    assign atk_sat = atk_sum[LEVEL_BITS] ? {LEVEL_BITS{1'b1}} : atk_sum[LEVEL_BITS-1:0];
    assign atk_hit = (atk_sat >= cfg.peak_level);
    assign atk_lvl = atk_hit ? cfg.peak_level : atk_sat;

    // Level times factor is below 2^32, so the Q0.16 result is bits 31:16
    assign prod_lvl   = prod[2*LEVEL_BITS-1:LEVEL_BITS];
    // Truncate toward zero: bump a negative quotient that dropped fraction bits
    assign prod_hi    = prod[MUL_P_W-1:LEVEL_BITS];
    assign prod_round = prod[MUL_P_W-1] && (prod[LEVEL_BITS-1:0] != '0);
    assign scaled     = prod_hi + (MUL_P_W-LEVEL_BITS)'(prod_round);

    always_comb begin
        state_next   = state_reg;
        post_next    = post_reg;
        env_next     = env_reg;
        trig_next    = trig_reg;
        held_next    = held_reg;
        atk_next     = atk_reg;
        dec_next     = dec_reg;
        rel_next     = rel_reg;
        ramp_next    = ramp_reg;
        lvl_next     = lvl_reg;
        sample_next  = sample_reg;
        start_next   = start_reg;
        stop_next    = stop_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mul_a        = '0;
        mul_b        = '0;

        // Drop the output beat once it is taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (s_data.action)
                        ACT_NOTE_ON: begin
                            trig_next = 1'b1;
                        end
                        ACT_NOTE_OFF: begin
                            trig_next = 1'b0;
                            held_next = 1'b0;
                        end
                        ACT_TICK: begin
                            sample_next = s_data.sample;
                            start_next  = 1'b0;
                            stop_next   = 1'b0;
                            state_next  = S_ENV;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Decide the phase; either set the level directly or send it
            // through the multiplier with the phase's factor.
            S_ENV: begin
                state_next = S_SCALE;
                mul_a      = MUL_A_W'(env_reg);
                if (!cfg.mode) begin
                    if (trig_reg && !held_reg) begin
                        atk_next  = 1'b1;
                        rel_next  = 1'b1;
                        trig_next = 1'b0;
                        if (env_reg >= cfg.floor_level) begin
                            ramp_next = 1'b1;
                        end else begin
                            start_next = 1'b1;
                        end
                    end
                    if (ramp_next) begin
                        mul_b      = MUL_B_W'(RAMP_FACTOR);
                        post_next  = P_RAMP;
                        state_next = S_POST;
                    end else if (atk_next) begin
                        env_next = atk_lvl;
                        lvl_next = atk_lvl;
                        if (atk_hit) begin
                            atk_next = 1'b0;
                        end
                    end else if (rel_next) begin
                        if (env_reg >= cfg.floor_level) begin
                            mul_b      = MUL_B_W'(cfg.release_factor);
                            post_next  = P_REL_AR;
                            state_next = S_POST;
                        end else begin
                            env_next  = '0;
                            lvl_next  = '0;
                            rel_next  = 1'b0;
                            stop_next = 1'b1;
                        end
                    end else begin
                        lvl_next = '0;
                    end
                end else begin
                    if (trig_reg && !held_reg) begin
                        atk_next   = 1'b1;
                        dec_next   = 1'b1;
                        held_next  = 1'b1;
                        rel_next   = 1'b1;
                        start_next = 1'b1;
                    end
                    if (atk_next) begin
                        env_next = atk_lvl;
                        lvl_next = atk_lvl;
                        if (atk_hit) begin
                            atk_next = 1'b0;
                        end
                    end else if (dec_next && (env_reg > cfg.sustain_level)) begin
                        mul_b      = MUL_B_W'(cfg.decay_factor);
                        post_next  = P_DECAY;
                        state_next = S_POST;
                    end else if (held_next) begin
                        env_next = cfg.sustain_level;
                        lvl_next = cfg.sustain_level;
                    end else if (rel_next) begin
                        mul_b      = MUL_B_W'(cfg.release_factor);
                        post_next  = P_REL_ADSR;
                        state_next = S_POST;
                    end else begin
                        lvl_next = '0;
                    end
                end
            end

            // Finish the phase on the scaled level
            S_POST: begin
                state_next = S_SCALE;
                env_next   = prod_lvl;
                lvl_next   = prod_lvl;
                case (post_reg)
                    P_RAMP: begin
                        if (prod_lvl <= cfg.floor_level) begin
                            env_next   = '0;
                            lvl_next   = '0;
                            ramp_next  = 1'b0;
                            start_next = 1'b1;
                        end
                    end
                    P_DECAY: begin
                        if (prod_lvl <= cfg.sustain_level) begin
                            env_next = cfg.sustain_level;
                            lvl_next = cfg.sustain_level;
                            dec_next = 1'b0;
                        end
                    end
                    P_REL_ADSR: begin
                        if (prod_lvl <= cfg.floor_level) begin
                            env_next  = '0;
                            lvl_next  = '0;
                            rel_next  = 1'b0;
                            stop_next = 1'b1;
                        end
                    end
                    default: begin
                        env_next = prod_lvl;
                    end
                endcase
            end

            S_SCALE: begin
                mul_a      = MUL_A_W'(sample_reg);
                mul_b      = MUL_B_W'(lvl_reg);
                state_next = S_DONE;
            end

            // Hold here until the output register is free; keep the sample
            // product steady while the output stalls
            S_DONE: begin
                mul_a = MUL_A_W'(sample_reg);
                mul_b = MUL_B_W'(lvl_reg);
                if (!m_valid_reg || m_ready) begin
                    m_data_next.level          = lvl_reg;
                    m_data_next.scaled_sample  = scaled[SAMPLE_BITS-1:0];
                    m_data_next.start_playback = start_reg;
                    m_data_next.stop_playback  = stop_reg;
                    m_valid_next               = 1'b1;
                    state_next                 = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            env_reg     <= '0;
            trig_reg    <= 1'b0;
            held_reg    <= 1'b0;
            atk_reg     <= 1'b0;
            dec_reg     <= 1'b0;
            rel_reg     <= 1'b0;
            ramp_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            env_reg     <= env_next;
            trig_reg    <= trig_next;
            held_reg    <= held_next;
            atk_reg     <= atk_next;
            dec_reg     <= dec_next;
            rel_reg     <= rel_next;
            ramp_reg    <= ramp_next;
            m_valid_reg <= m_valid_next;
            post_reg    <= post_next;
            lvl_reg     <= lvl_next;
            sample_reg  <= sample_next;
            start_reg   <= start_next;
            stop_reg    <= stop_next;
            m_data_reg  <= m_data_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A non-tick beat is absorbed in S_IDLE and leaves the block ready in the next cycle
    a_note_stays_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.action != ACT_TICK)) |=> s_ready)
        else $error("note event did not leave the sequencer idle");

    // A new output beat only comes from the final sequencer step
    a_beat_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("output beat loaded outside the final step");

    // Start and stop never mark the same tick
    a_start_stop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.start_playback && m_data.stop_playback))
        else $error("start and stop flagged on one tick");

    // Stopping always lands on a silent level
    a_stop_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.stop_playback) |-> (m_data.level == '0))
        else $error("stop flagged with nonzero level");

endmodule

// File: sv/adsr_eg_cfg.sv
// Configuration register file of the envelope generator.
// Depends on adsr_eg_pkg for register codes, reset values and cfg_regs_t.
module adsr_eg_cfg
    import adsr_eg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [LEVEL_BITS-1:0] cfg_wdata,
    output cfg_regs_t             cfg
);

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MODE:           cfg_next.mode           = cfg_wdata[0];
                CFG_ATTACK_STEP:    cfg_next.attack_step    = cfg_wdata;
                CFG_PEAK_LEVEL:     cfg_next.peak_level     = cfg_wdata;
                CFG_DECAY_FACTOR:   cfg_next.decay_factor   = cfg_wdata;
                CFG_SUSTAIN_LEVEL:  cfg_next.sustain_level  = cfg_wdata;
                CFG_RELEASE_FACTOR: cfg_next.release_factor = cfg_wdata;
                CFG_FLOOR_LEVEL:    cfg_next.floor_level    = cfg_wdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode           <= RST_MODE;
            cfg_reg.attack_step    <= RST_ATTACK_STEP;
            cfg_reg.peak_level     <= RST_PEAK_LEVEL;
            cfg_reg.decay_factor   <= RST_DECAY_FACTOR;
            cfg_reg.sustain_level  <= RST_SUSTAIN_LEVEL;
            cfg_reg.release_factor <= RST_RELEASE_FACTOR;
            cfg_reg.floor_level    <= RST_FLOOR_LEVEL;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/adsr_eg_mul.sv
// Shared signed multiplier with registered product, used for level factors
// and sample scaling. Depends on adsr_eg_pkg for operand widths.
module adsr_eg_mul
    import adsr_eg_pkg::*;
(
    input  logic                      aclk,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic signed [MUL_B_W-1:0] op_b,
    output logic signed [MUL_P_W-1:0] prod
);

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

// File: sim/tb_ar_adsr_envelope_generator.sv
// Self-checking bench for ar_adsr_envelope_generator: a directed stimulus table,
// then random note/tick sequences under varying register settings.
// Depends on adsr_eg_pkg and the block's RTL; results are checked by an in-bench predictor.
module tb_ar_adsr_envelope_generator;
    import adsr_eg_pkg::*;

    // The block ignores the fourth action code; name it for the stimulus.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 900;
    // Slack after the last result: a note beat may still be in the sequencer.
    localparam int SETTLE_CYCLES = 12;

    typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

    // One line of the directed table: either a beat or a register write.
    typedef struct {
        row_kind_t             kind;
        in_item_t              beat;
        bit                    typed;
        out_item_t             want;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [LEVEL_BITS-1:0] reg_val;
    } dir_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [LEVEL_BITS-1:0] cfg_wdata = '0;

    ar_adsr_envelope_generator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Envelope predictor: its own copy of the registers and phase flags.
    // ------------------------------------------------------------------
    cfg_regs_t             regs_model;
    logic [LEVEL_BITS-1:0] env;
    bit                    trig_pend, held, in_attack, in_decay, in_release, in_rampdown;

    out_item_t due_levels[$];   // expected result beats, oldest first
    dir_row_t  script[$];

    int errors         = 0;
    int items_sent     = 0;
    int levels_checked = 0;
    int starts_seen    = 0;
    int stops_seen     = 0;
    int phases_run     = 0;
    int cycle_cnt      = 0;
    int burst_left     = 0;
    bit gaps_on        = 1'b1;

    function automatic logic [LEVEL_BITS-1:0] q16_mul(input logic [LEVEL_BITS-1:0] a,
                                                      input logic [LEVEL_BITS-1:0] b);
        logic [31:0] p;
        p = {16'd0, a} * {16'd0, b};
        return p[31:16];
    endfunction

    function automatic void reset_model();
        regs_model.mode           = RST_MODE;
        regs_model.attack_step    = RST_ATTACK_STEP;
        regs_model.peak_level     = RST_PEAK_LEVEL;
        regs_model.decay_factor   = RST_DECAY_FACTOR;
        regs_model.sustain_level  = RST_SUSTAIN_LEVEL;
        regs_model.release_factor = RST_RELEASE_FACTOR;
        regs_model.floor_level    = RST_FLOOR_LEVEL;
        env         = '0;
        trig_pend   = 1'b0;
        held        = 1'b0;
        in_attack   = 1'b0;
        in_decay    = 1'b0;
        in_release  = 1'b0;
        in_rampdown = 1'b0;
    endfunction

    function automatic void set_model_reg(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [LEVEL_BITS-1:0] val);
        case (idx)
            CFG_MODE:           regs_model.mode           = val[0];
            CFG_ATTACK_STEP:    regs_model.attack_step    = val;
            CFG_PEAK_LEVEL:     regs_model.peak_level     = val;
            CFG_DECAY_FACTOR:   regs_model.decay_factor   = val;
            CFG_SUSTAIN_LEVEL:  regs_model.sustain_level  = val;
            CFG_RELEASE_FACTOR: regs_model.release_factor = val;
            CFG_FLOOR_LEVEL:    regs_model.floor_level    = val;
            default: ;
        endcase
    endfunction

    // Add the attack step, saturate, then clamp at the peak.
    function automatic void climb_attack();
        logic [LEVEL_BITS:0] sum;
        sum = {1'b0, env} + {1'b0, regs_model.attack_step};
        if (sum[LEVEL_BITS])
            sum = {1'b0, {LEVEL_BITS{1'b1}}};
        env = sum[LEVEL_BITS-1:0];
        if (env >= regs_model.peak_level) begin
            env       = regs_model.peak_level;
            in_attack = 1'b0;
        end
    endfunction

    // Advance the envelope by one beat; returns 1 when the beat yields a result.
    function automatic bit envelope_step(input in_item_t it, output out_item_t res);
        logic [LEVEL_BITS-1:0] lvl;
        bit                    start, stop;
        longint                prod;
        res   = '0;
        lvl   = '0;
        start = 1'b0;
        stop  = 1'b0;
        case (it.action)
            ACT_NOTE_ON: begin
                trig_pend = 1'b1;
                return 1'b0;
            end
            ACT_NOTE_OFF: begin
                trig_pend = 1'b0;
                held      = 1'b0;
                return 1'b0;
            end
            ACT_TICK: ;
            default: return 1'b0;
        endcase

        if (!regs_model.mode) begin
            // Attack-release: a re-trigger at or above the floor ramps down first.
            if (trig_pend && !held) begin
                in_attack  = 1'b1;
                in_release = 1'b1;
                trig_pend  = 1'b0;
                if (env >= regs_model.floor_level)
                    in_rampdown = 1'b1;
                else
                    start = 1'b1;
            end
            if (in_rampdown) begin
                env = q16_mul(env, RAMP_FACTOR);
                if (env <= regs_model.floor_level) begin
                    env         = '0;
                    in_rampdown = 1'b0;
                    start       = 1'b1;
                end
                lvl = env;
            end else if (in_attack) begin
                climb_attack();
                lvl = env;
            end else if (in_release) begin
                if (env >= regs_model.floor_level) begin
                    env = q16_mul(env, regs_model.release_factor);
                    lvl = env;
                end else begin
                    env        = '0;
                    in_release = 1'b0;
                    stop       = 1'b1;
                end
            end
        end else begin
            // Attack-decay-sustain-release: the trigger stays pending while held.
            if (trig_pend && !held) begin
                in_attack  = 1'b1;
                in_decay   = 1'b1;
                held       = 1'b1;
                in_release = 1'b1;
                start      = 1'b1;
            end
            if (in_attack) begin
                climb_attack();
                lvl = env;
            end else if (in_decay && env > regs_model.sustain_level) begin
                env = q16_mul(env, regs_model.decay_factor);
                if (env <= regs_model.sustain_level) begin
                    env      = regs_model.sustain_level;
                    in_decay = 1'b0;
                end
                lvl = env;
            end else if (held) begin
                env = regs_model.sustain_level;
                lvl = env;
            end else if (in_release) begin
                env = q16_mul(env, regs_model.release_factor);
                if (env <= regs_model.floor_level) begin
                    env        = '0;
                    in_release = 1'b0;
                    stop       = 1'b1;
                end
                lvl = env;
            end
        end

        // Signed sample times unsigned level, truncated toward zero.
        prod = longint'($signed(it.sample)) * longint'(lvl);
        prod = prod / 65536;
        res.level          = lvl;
        res.scaled_sample  = prod[SAMPLE_BITS-1:0];
        res.start_playback = start;
        res.stop_playback  = stop;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic in_item_t mk_beat(input logic [1:0] act, input logic [SAMPLE_BITS-1:0] smp);
        in_item_t it;
        it.action = act;
        it.sample = smp;
        return it;
    endfunction

    // Bias toward the sample extremes now and then.
    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic void add_beat(input logic [1:0] act, input logic [SAMPLE_BITS-1:0] smp);
        dir_row_t r;
        r = '{kind: ROW_BEAT, beat: mk_beat(act, smp), typed: 1'b0, want: '0,
              reg_idx: '0, reg_val: '0};
        script.push_back(r);
    endfunction

    function automatic void add_checked(input logic [1:0] act, input logic [SAMPLE_BITS-1:0] smp,
                                        input out_item_t want);
        dir_row_t r;
        r = '{kind: ROW_BEAT, beat: mk_beat(act, smp), typed: 1'b1, want: want,
              reg_idx: '0, reg_val: '0};
        script.push_back(r);
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [LEVEL_BITS-1:0] val);
        dir_row_t r;
        r = '{kind: ROW_REG, beat: '0, typed: 1'b0, want: '0, reg_idx: idx, reg_val: val};
        script.push_back(r);
    endfunction

    // Hold the beat until it is taken, then log what it should produce.
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
        out_item_t res;
        if (burst_left == 0) begin
            if (gaps_on) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        if (envelope_step(it, res))
            due_levels.push_back(typed ? want : res);
        if (it.action != ACT_UNUSED)
            items_sent++;
    endtask

    task automatic ticks(input int n);
        repeat (n) send_item(mk_beat(ACT_TICK, rand_sample()), 1'b0, '0);
    endtask

    task automatic note(input logic [1:0] act);
        send_item(mk_beat(act, rand_sample()), 1'b0, '0);
    endtask

    // Drop valid and drain every outstanding result, then let the sequencer settle.
    task automatic quiesce();
        s_valid <= 1'b0;
        while (due_levels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Caller lowers cfg_wr_en after the last write of a batch.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        set_model_reg(idx, val);
    endtask

    // Pick a register set for one random phase: the first three are the
    // all-ones, all-zero and reset corners, the rest random.
    task automatic program_phase_regs(input int phase);
        cfg_regs_t plan;
        case (phase)
            0: plan = '1;
            1: plan = '0;
            2: begin
                plan.mode           = RST_MODE;
                plan.attack_step    = RST_ATTACK_STEP;
                plan.peak_level     = RST_PEAK_LEVEL;
                plan.decay_factor   = RST_DECAY_FACTOR;
                plan.sustain_level  = RST_SUSTAIN_LEVEL;
                plan.release_factor = RST_RELEASE_FACTOR;
                plan.floor_level    = RST_FLOOR_LEVEL;
            end
            default: begin
                plan.mode           = 1'($urandom_range(0, 1));
                // Mostly large steps so the attack ends within a note.
                plan.attack_step    = LEVEL_BITS'(($urandom_range(0, 5) == 0)
                                                  ? $urandom_range(0, 999)
                                                  : $urandom_range(1000, 65535));
                plan.peak_level     = LEVEL_BITS'($urandom);
                plan.decay_factor   = LEVEL_BITS'($urandom_range(0, 64000));
                plan.sustain_level  = LEVEL_BITS'($urandom);
                plan.release_factor = LEVEL_BITS'($urandom_range(0, 64000));
                // A high floor shortens the 0.999 ramp-down.
                case ($urandom_range(0, 3))
                    0:       plan.floor_level = LEVEL_BITS'($urandom_range(0, 200));
                    1:       plan.floor_level = LEVEL_BITS'($urandom_range(200, 20000));
                    2:       plan.floor_level = LEVEL_BITS'($urandom_range(40000, 65000));
                    default: plan.floor_level = LEVEL_BITS'($urandom);
                endcase
            end
        endcase
        quiesce();
        write_reg(CFG_MODE,           {{(LEVEL_BITS-1){1'b0}}, plan.mode});
        write_reg(CFG_ATTACK_STEP,    plan.attack_step);
        write_reg(CFG_PEAK_LEVEL,     plan.peak_level);
        write_reg(CFG_DECAY_FACTOR,   plan.decay_factor);
        write_reg(CFG_SUSTAIN_LEVEL,  plan.sustain_level);
        write_reg(CFG_RELEASE_FACTOR, plan.release_factor);
        write_reg(CFG_FLOOR_LEVEL,    plan.floor_level);
        cfg_wr_en <= 1'b0;
    endtask

    // A well-formed note: on, some ticks, maybe a re-trigger, usually an off, a tail.
    task automatic play_note();
        note(ACT_NOTE_ON);
        ticks($urandom_range(1, 30));
        if ($urandom_range(0, 2) == 0) begin
            note(ACT_NOTE_ON);
            ticks($urandom_range(1, 20));
        end
        if ($urandom_range(0, 4) != 0)
            note(ACT_NOTE_OFF);
        // Long tails now and then, so release and ramp-down reach the floor.
        ticks(($urandom_range(0, 4) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 40));
    endtask

    task automatic play_noise();
        in_item_t it;
        repeat ($urandom_range(1, 6)) begin
            it.action = 2'($urandom_range(0, 3));
            it.sample = rand_sample();
            send_item(it, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking and receiver stalls
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string field, input int exp_v, input int act_v);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
        errors++;
    endtask

    out_item_t rx_want;
    int        stall_left = 0;

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (due_levels.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got level %0d",
                         $time, m_data.level);
                errors++;
            end else begin
                rx_want = due_levels.pop_front();
                levels_checked++;
                if (m_data.level !== rx_want.level)
                    report_mismatch("level", rx_want.level, m_data.level);
                if (m_data.scaled_sample !== rx_want.scaled_sample)
                    report_mismatch("scaled_sample", $signed(rx_want.scaled_sample),
                                    $signed(m_data.scaled_sample));
                if (m_data.start_playback !== rx_want.start_playback)
                    report_mismatch("start_playback", rx_want.start_playback,
                                    m_data.start_playback);
                if (m_data.stop_playback !== rx_want.stop_playback)
                    report_mismatch("stop_playback", rx_want.stop_playback,
                                    m_data.stop_playback);
                starts_seen += rx_want.start_playback;
                stops_seen  += rx_want.stop_playback;
            end
        end
        // Stall in short random runs, with a regular stretch in which m_ready stays high.
        if ((cycle_cnt % 2048) < 400) begin
            m_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: end the run if it never completes.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, due_levels.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int rand_base;
        int phase_end;
        reset_model();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Idle ticks at reset settings give silence at both sample extremes.
        add_checked(ACT_TICK, 16'h7FFF, out_item_t'({16'd0, 16'd0, 1'b0, 1'b0}));
        add_checked(ACT_TICK, 16'h8000, out_item_t'({16'd0, 16'd0, 1'b0, 1'b0}));
        add_beat(ACT_UNUSED, 16'hFFFF);
        add_beat(ACT_NOTE_OFF, 16'h5555);
        add_beat(ACT_NOTE_ON, 16'hAAAA);
        // First AR tick below the floor: start at once, attack by one step.
        add_checked(ACT_TICK, 16'h7FFF, out_item_t'({16'd1, 16'd0, 1'b1, 1'b0}));
        add_beat(ACT_TICK, 16'h8000);
        // Attack overflow saturates, release drops to zero, then stops.
        add_reg(CFG_ATTACK_STEP, 16'hFFFF);
        add_reg(CFG_PEAK_LEVEL, 16'hFFFF);
        add_reg(CFG_RELEASE_FACTOR, 16'h0000);
        add_beat(ACT_TICK, 16'h7FFF);
        add_beat(ACT_TICK, 16'hFFFF);
        add_beat(ACT_TICK, 16'h0064);
        add_beat(ACT_NOTE_ON, 16'h0000);
        add_beat(ACT_TICK, 16'h8000);
        // Re-trigger at full level: ramp down first.
        add_beat(ACT_NOTE_ON, 16'h0000);
        add_beat(ACT_TICK, 16'h7FFF);
        add_beat(ACT_TICK, 16'h8001);
        // Switch to ADSR with phase flags still set from AR.
        add_reg(CFG_MODE, 16'd1);
        add_reg(CFG_ATTACK_STEP, 16'd30000);
        add_reg(CFG_PEAK_LEVEL, 16'd60000);
        add_reg(CFG_DECAY_FACTOR, 16'd32768);
        add_reg(CFG_SUSTAIN_LEVEL, 16'd20000);
        add_reg(CFG_RELEASE_FACTOR, 16'd32768);
        add_beat(ACT_NOTE_ON, 16'h1234);
        add_beat(ACT_TICK, 16'h7FFF);
        add_beat(ACT_TICK, 16'h8000);
        // Decay undershoots sustain and is clamped to it.
        add_beat(ACT_TICK, 16'h4000);
        // Second note-on while held stays pending and does not restart.
        add_beat(ACT_NOTE_ON, 16'h0000);
        add_beat(ACT_TICK, 16'hC000);
        add_beat(ACT_NOTE_OFF, 16'h0000);
        add_beat(ACT_TICK, 16'h7FFF);
        add_reg(CFG_FLOOR_LEVEL, 16'hFFFF);
        add_beat(ACT_TICK, 16'h8000);
        add_beat(ACT_TICK, 16'h0001);

        foreach (script[i]) begin
            if (script[i].kind == ROW_REG) begin
                quiesce();
                write_reg(script[i].reg_idx, script[i].reg_val);
                cfg_wr_en <= 1'b0;
            end else begin
                send_item(script[i].beat, script[i].typed, script[i].want);
            end
        end

        // Random phases: new registers, then a mix of notes and noise.
        rand_base = items_sent;
        while (items_sent - rand_base < RANDOM_ITEMS) begin
            program_phase_regs(phases_run);
            gaps_on = (phases_run % 4) != 3;
            phase_end = items_sent + $urandom_range(50, 90);
            // Keep the last phase from running far past the item budget.
            if (phase_end > rand_base + RANDOM_ITEMS)
                phase_end = rand_base + RANDOM_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 9) < 7)
                    play_note();
                else
                    play_noise();
                // Hold off the sender until every result is back.
                if ($urandom_range(0, 7) == 0)
                    quiesce();
            end
            phases_run++;
        end

        quiesce();
        if (due_levels.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, due_levels.size());
            errors += due_levels.size();
        end
        $display("Run covered %0d beats over %0d register phases; %0d results checked.",
                 items_sent, phases_run, levels_checked);
        $display("Playback flags seen: %0d starts, %0d stops.", starts_seen, stops_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
sv/adsr_eg_pkg.sv
sv/adsr_eg_cfg.sv
sv/adsr_eg_mul.sv
sv/ar_adsr_envelope_generator.sv
sim/tb_ar_adsr_envelope_generator.sv
